>>> rtl/fir_filter_q15_defines.svh
// ----------------------------------------------------------------------------
// fir_filter_q15_defines.svh
// Assertion macros used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_Q15_DEFINES_SVH
`define FIR_FILTER_Q15_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on clk, masked while reset is asserted.
`define FIR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk, also during reset.
`define FIR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FIR_ASSERT(label, prop, msg)
`define FIR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/fir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_pkg
// Types, tap table and constants of the Q15 FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

    localparam int TABLE_TAPS = 31;
    localparam int TAP_IDX_W  = 6;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    localparam int FRAC_BITS  = 15;

    localparam logic signed [COEF_W-1:0] TAP_TABLE [TABLE_TAPS] = '{
        -16'sd141, -16'sd5, -16'sd119, 16'sd158, 16'sd118, 16'sd677, 16'sd787,
        16'sd1685, 16'sd1946, 16'sd3122, 16'sd3422, 16'sd4684, 16'sd4819,
        16'sd5908, 16'sd5674, 16'sd6372, 16'sd5674, 16'sd5908, 16'sd4819,
        16'sd4684, 16'sd3422, 16'sd3122, 16'sd1946, 16'sd1685, 16'sd787,
        16'sd677, 16'sd118, 16'sd158, -16'sd119, -16'sd5, -16'sd141
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } fir_state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    function automatic logic signed [COEF_W-1:0] fir_tap(input logic [TAP_IDX_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        if (k < TAP_IDX_W'(TABLE_TAPS)) begin
            c = TAP_TABLE[k[4:0]];
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

>>> rtl/fir_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_hist_ram
// Sample history memory, one read and one write port, registered read.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module fir_hist_ram
    import fir_pkg::*;
#(
    parameter int DEPTH = 30,
    parameter int AW    = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic                       rvld_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

>>> rtl/fir_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_mac
// Multiply-accumulate unit: registered product, then exact accumulation.
// ----------------------------------------------------------------------------
module fir_mac
    import fir_pkg::*;
#(
    parameter int ACC_W = 37
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   op,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] smp,
    output logic signed [ACC_W-1:0]    acc,
    output logic                       done
);

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 pctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    always_comb begin
        if (pctl_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= coef * smp;
        if (pctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pctl_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            pctl_reg <= op;
            done_reg <= pctl_reg.valid & pctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

>>> rtl/fir_filter_q15.sv
// One sample is processed at a time: a new sample is taken only when idle, as the
// single history read port and multiplier work through one tap per cycle.
// A finished result waits in the accumulator until the output register is free; no new sample is taken meanwhile.
// Reset: asynchronous, clears control, history valid bits and write pointer.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_q15
// Direct-form Q15 FIR filter with a circular sample history in memory.
// ----------------------------------------------------------------------------
`include "fir_filter_q15_defines.svh"

module fir_filter_q15
    import fir_pkg::*;
#(
    parameter int TAP_COUNT = 31
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    output logic signed [SAMPLE_W-1:0] filtered,
    output logic                       filtered_valid,
    input  logic                       filtered_ready
);

    localparam int HIST_DEPTH = TAP_COUNT - 1;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int K_W        = $clog2(TAP_COUNT);
    localparam int ACC_W      = PROD_W + $clog2(TAP_COUNT);

    fir_state_t                 state_reg, state_next;
    logic [K_W-1:0]             step_reg, step_next;
    logic [K_W-1:0]             k_reg, k_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic [HIST_AW-1:0]         wp_reg, wp_next;
    logic [HIST_AW-1:0]         rd_addr_reg, rd_addr_next;
    mac_ctl_t                   op_reg, op_next;
    logic signed [SAMPLE_W-1:0] filt_reg, filt_next;
    logic                       fvalid_reg, fvalid_next;

    logic                       accept;
    logic                       last_step;
    logic                       slot_free;
    logic                       load_out;
    logic                       hist_rd_en;
    logic                       hist_wr_en;
    logic signed [SAMPLE_W-1:0] hist_rd_data;
    logic signed [SAMPLE_W-1:0] mac_smp;
    logic signed [COEF_W-1:0]   mac_coef;
    logic signed [ACC_W-1:0]    mac_acc;
    logic                       mac_done;

    assign accept    = sample_valid & sample_ready;
    assign last_step = (step_reg == K_W'(TAP_COUNT - 1));
    assign slot_free = !fvalid_reg || filtered_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample_valid) state_next = ST_RUN;
            ST_RUN:   if (last_step) state_next = ST_DRAIN;
            ST_DRAIN: if (mac_done) state_next = slot_free ? ST_IDLE : ST_OUT;
            ST_OUT:   if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        sample_ready = 1'b0;
        hist_rd_en   = 1'b0;
        load_out     = 1'b0;
        op_next      = '0;
        unique case (state_reg)
            ST_IDLE:  sample_ready = 1'b1;
            ST_RUN:
            begin
                hist_rd_en    = (step_reg != '0);
                op_next.valid = 1'b1;
                op_next.first = (step_reg == '0);
                op_next.last  = last_step;
            end
            ST_DRAIN: load_out = mac_done & slot_free;
            ST_OUT:   load_out = slot_free;
            default:  sample_ready = 1'b0;
        endcase
    end

    assign hist_wr_en = load_out;

    always_comb begin
        step_next    = step_reg;
        k_next       = step_reg;
        x_next       = x_reg;
        wp_next      = wp_reg;
        rd_addr_next = rd_addr_reg;
        filt_next    = filt_reg;
        fvalid_next  = fvalid_reg;
        if (accept) begin
            x_next       = sample;
            step_next    = '0;
            rd_addr_next = (wp_reg == '0) ? HIST_AW'(HIST_DEPTH - 1) : wp_reg - 1'b1;
        end
        if (state_reg == ST_RUN) begin
            step_next = step_reg + 1'b1;
        end
        if (hist_rd_en) begin
            rd_addr_next = (rd_addr_reg == '0) ? HIST_AW'(HIST_DEPTH - 1)
                                               : rd_addr_reg - 1'b1;
        end
        if (filtered_valid && filtered_ready) begin
            fvalid_next = 1'b0;
        end
        if (load_out) begin
            filt_next   = mac_acc[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            fvalid_next = 1'b1;
            wp_next     = (wp_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            wp_reg     <= '0;
            op_reg     <= '0;
            fvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            wp_reg     <= wp_next;
            op_reg     <= op_next;
            fvalid_reg <= fvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        k_reg       <= k_next;
        x_reg       <= x_next;
        rd_addr_reg <= rd_addr_next;
        filt_reg    <= filt_next;
    end

    fir_hist_ram #(
        .DEPTH (HIST_DEPTH),
        .AW    (HIST_AW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (hist_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (hist_rd_data),
        .wr_en   (hist_wr_en),
        .wr_addr (wp_reg),
        .wr_data (x_reg)
    );

    assign mac_smp  = op_reg.first ? x_reg : hist_rd_data;
    assign mac_coef = fir_tap(TAP_IDX_W'(k_reg));

    fir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_reg),
        .coef  (mac_coef),
        .smp   (mac_smp),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign filtered       = filt_reg;
    assign filtered_valid = fvalid_reg;

    `FIR_ASSERT(a_done_in_drain, mac_done |-> (state_reg == ST_DRAIN), "MAC done outside drain")
    `FIR_ASSERT(a_no_rd_wr_overlap, hist_wr_en |-> !hist_rd_en, "history read and write overlap")
    `FIR_ASSERT(a_accept_starts_run, accept |=> (state_reg == ST_RUN && step_reg == '0), "transfer did not start run")
    `FIR_ASSERT_ALWAYS(a_op_only_in_run, op_reg.valid |-> $past(state_reg == ST_RUN), "MAC op issued outside run")

endmodule
